@@ design/y2b_pkg.sv @@
// Shared types and constants for the YUY2 to BGRA converter.
// No dependencies; imported by every module of the block.
package y2b_pkg;

  localparam int LINE_PAIRS_W = 11;
  localparam logic [LINE_PAIRS_W-1:0] LINE_PAIRS_RESET = 11'd320;

  localparam int DEF_MAX_LINE_PAIRS = 1024;
  localparam int DEF_COEF_FRAC_BITS = 14;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LINE_PAIRS = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] luma_odd;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       end_of_line;
  } y2b_item_t;

endpackage

@@ design/yuy2_to_bgra_converter.sv @@
// Top level of the YUY2 to BGRA converter: APB register, front end, queue, back end.
// Depends on y2b_pkg, y2b_front, y2b_queue and y2b_back.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  luma_even chroma_blue luma_odd chroma_red frame_start
//   output    out_valid/out_stall  first_* second_* (blue green red) end_of_line
//   config    APB psel/penable     paddr pwdata prdata, line_pairs at byte 0
//
// One macropixel per cycle sustained while out_stall is low; out_valid rises after the request
// passes line store read, queue write, multiply stage and clamp into the output register.
// The line store has a single port, written on even rows; its read data is used on odd rows.
// rst is synchronous; the line store is not cleared and holds data only once written.
// out_stall freezes the back end; the queue absorbs the front until it fills, then in_stall rises.
module yuy2_to_bgra_converter import y2b_pkg::*; #(
  parameter int MAX_LINE_PAIRS = DEF_MAX_LINE_PAIRS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         luma_even,
  input  logic [7:0]         chroma_blue,
  input  logic [7:0]         luma_odd,
  input  logic [7:0]         chroma_red,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         first_blue,
  output logic [7:0]         first_green,
  output logic [7:0]         first_red,
  output logic [7:0]         second_blue,
  output logic [7:0]         second_green,
  output logic [7:0]         second_red,
  output logic               end_of_line
);

  logic [LINE_PAIRS_W-1:0] line_pairs;
  logic                    reg_hit;

  logic              push;
  y2b_item_t         push_item;
  logic              pop;
  y2b_item_t         head;
  logic [QCNT_W-1:0] q_count;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_LINE_PAIRS);
  assign prdata  = reg_hit ? PDATA_W'(line_pairs) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pairs <= LINE_PAIRS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      line_pairs <= pwdata[LINE_PAIRS_W-1:0];
    end
  end

  y2b_front #(
    .MAX_LINE_PAIRS(MAX_LINE_PAIRS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .line_pairs (line_pairs),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .luma_even  (luma_even),
    .chroma_blue(chroma_blue),
    .luma_odd   (luma_odd),
    .chroma_red (chroma_red),
    .frame_start(frame_start),
    .q_count    (q_count),
    .push       (push),
    .push_item  (push_item)
  );

  y2b_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  y2b_back #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_count     (q_count),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .first_blue  (first_blue),
    .first_green (first_green),
    .first_red   (first_red),
    .second_blue (second_blue),
    .second_green(second_green),
    .second_red  (second_red),
    .end_of_line (end_of_line)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("push into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_count != '0)
    else $error("pop from an empty queue");

  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> q_count < QCNT_W'(QUEUE_DEPTH))
    else $error("request accepted without queue room");

endmodule

@@ design/y2b_front.sv @@
// Front end: accepts macropixel requests, tracks row and column, keeps the chroma line store.
// Depends on y2b_pkg; feeds y2b_queue.
module y2b_front import y2b_pkg::*; #(
  parameter int MAX_LINE_PAIRS = DEF_MAX_LINE_PAIRS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [LINE_PAIRS_W-1:0] line_pairs,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              luma_even,
  input  logic [7:0]              chroma_blue,
  input  logic [7:0]              luma_odd,
  input  logic [7:0]              chroma_red,
  input  logic                    frame_start,
  input  logic [QCNT_W-1:0]       q_count,
  output logic                    push,
  output y2b_item_t               push_item
);

  localparam int COL_W = $clog2(MAX_LINE_PAIRS);
  localparam int CMP_W = ((COL_W + 1 > LINE_PAIRS_W) ? COL_W + 1 : LINE_PAIRS_W) + 1;

  logic [COL_W-1:0] column_count;
  logic             odd_row;
  logic [15:0]      chroma_line [MAX_LINE_PAIRS];
  logic [15:0]      line_rdata;

  logic             f1_valid;
  y2b_item_t        f1_item;
  logic             f1_odd;

  logic             accept;
  logic [COL_W-1:0] col_cur;
  logic             odd_cur;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] eff;
  logic             last;

  assign in_stall = ({1'b0, q_count} + {{QCNT_W{1'b0}}, f1_valid}) >=
                    (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_cur = frame_start ? '0 : column_count;
    odd_cur = frame_start ? 1'b0 : odd_row;
    col_inc = CMP_W'(col_cur) + CMP_W'(1);
    eff     = (line_pairs == '0) ? CMP_W'(1) : CMP_W'(line_pairs);
    last    = (col_inc >= eff) || (col_inc >= CMP_W'(MAX_LINE_PAIRS));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!odd_cur) begin
        chroma_line[col_cur] <= {chroma_red, chroma_blue};
      end
      line_rdata <= chroma_line[col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      odd_row      <= 1'b0;
      f1_valid     <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        column_count <= last ? '0 : col_inc[COL_W-1:0];
        odd_row      <= last ? !odd_cur : odd_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_item.luma_even   <= luma_even;
      f1_item.luma_odd    <= luma_odd;
      f1_item.chroma_blue <= chroma_blue;
      f1_item.chroma_red  <= chroma_red;
      f1_item.end_of_line <= last;
      f1_odd              <= odd_cur;
    end
  end

  // reuse the stored chroma on odd rows
  always_comb begin
    push      = f1_valid;
    push_item = f1_item;
    if (f1_odd) begin
      push_item.chroma_blue = line_rdata[7:0];
      push_item.chroma_red  = line_rdata[15:8];
    end
  end

endmodule

@@ design/y2b_queue.sv @@
// Short queue between the front end and the conversion back end.
// Depends on y2b_pkg for the item type and depth.
module y2b_queue import y2b_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  y2b_item_t         push_item,
  input  logic              pop,
  output y2b_item_t         head,
  output logic [QCNT_W-1:0] count
);

  y2b_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/y2b_back.sv @@
// Back end: BT.601 multiply stage, then sum, truncate and clamp into the output register.
// Depends on y2b_pkg; drains y2b_queue.
module y2b_back import y2b_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [QCNT_W-1:0] q_count,
  input  y2b_item_t         head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        first_blue,
  output logic [7:0]        first_green,
  output logic [7:0]        first_red,
  output logic [7:0]        second_blue,
  output logic [7:0]        second_green,
  output logic [7:0]        second_red,
  output logic              end_of_line
);

  localparam int CW = COEF_FRAC_BITS + 3;
  localparam int PW = CW + 9;
  localparam int SW = PW + 2;

  localparam longint KY_L = ((longint'(11644) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint KR_L = ((longint'(15960) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint KGU_L = ((longint'(3918) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint KGV_L = ((longint'(8130) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint KB_L = ((longint'(20172) << COEF_FRAC_BITS) + 5000) / 10000;

  localparam logic signed [CW-1:0] KY  = CW'(KY_L);
  localparam logic signed [CW-1:0] KR  = CW'(KR_L);
  localparam logic signed [CW-1:0] KGU = CW'(KGU_L);
  localparam logic signed [CW-1:0] KGV = CW'(KGV_L);
  localparam logic signed [CW-1:0] KB  = CW'(KB_L);

  function automatic logic [7:0] clamp(input logic signed [SW-1:0] sum);
    logic [7:0] res;
    if (sum[SW-1] || (sum == '0)) begin
      res = 8'd0;
    end else if (|sum[SW-2:COEF_FRAC_BITS+8]) begin
      res = 8'd255;
    end else begin
      res = sum[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    return res;
  endfunction

  logic advance;

  logic signed [8:0] y0;
  logic signed [8:0] y1;
  logic signed [8:0] u;
  logic signed [8:0] v;

  logic                 b1_valid;
  logic signed [PW-1:0] ty0;
  logic signed [PW-1:0] ty1;
  logic signed [PW-1:0] pbu;
  logic signed [PW-1:0] pgu;
  logic signed [PW-1:0] pgv;
  logic signed [PW-1:0] prv;
  logic                 b1_eol;

  logic signed [SW-1:0] sb0;
  logic signed [SW-1:0] sg0;
  logic signed [SW-1:0] sr0;
  logic signed [SW-1:0] sb1;
  logic signed [SW-1:0] sg1;
  logic signed [SW-1:0] sr1;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && (q_count != '0);

  always_comb begin
    y0 = $signed({1'b0, head.luma_even}) - 9'sd16;
    y1 = $signed({1'b0, head.luma_odd}) - 9'sd16;
    u  = $signed({1'b0, head.chroma_blue}) - 9'sd128;
    v  = $signed({1'b0, head.chroma_red}) - 9'sd128;
  end

  always_comb begin
    sb0 = SW'(ty0) + SW'(pbu);
    sg0 = SW'(ty0) - SW'(pgu) - SW'(pgv);
    sr0 = SW'(ty0) + SW'(prv);
    sb1 = SW'(ty1) + SW'(pbu);
    sg1 = SW'(ty1) - SW'(pgu) - SW'(pgv);
    sr1 = SW'(ty1) + SW'(prv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      b1_valid  <= pop;
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ty0    <= PW'(KY * y0);
      ty1    <= PW'(KY * y1);
      pbu    <= PW'(KB * u);
      pgu    <= PW'(KGU * u);
      pgv    <= PW'(KGV * v);
      prv    <= PW'(KR * v);
      b1_eol <= head.end_of_line;

      first_blue   <= clamp(sb0);
      first_green  <= clamp(sg0);
      first_red    <= clamp(sr0);
      second_blue  <= clamp(sb1);
      second_green <= clamp(sg1);
      second_red   <= clamp(sr1);
      end_of_line  <= b1_eol;
    end
  end

endmodule

@@ test/yuy2_to_bgra_converter_tb.sv @@
// Self-checking bench for yuy2_to_bgra_converter: drives macropixel requests, predicts the
// converted pixel pairs and checks each output request field by field.
// Depends on y2b_pkg and the converter RTL.
module yuy2_to_bgra_converter_tb;
  import y2b_pkg::*;

  localparam int FRAC = DEF_COEF_FRAC_BITS;
  localparam int MAX_PAIRS = DEF_MAX_LINE_PAIRS;
  localparam longint K_Y  = ((longint'(11644) <<< FRAC) + 5000) / 10000;
  localparam longint K_RV = ((longint'(15960) <<< FRAC) + 5000) / 10000;
  localparam longint K_GU = ((longint'(3918) <<< FRAC) + 5000) / 10000;
  localparam longint K_GV = ((longint'(8130) <<< FRAC) + 5000) / 10000;
  localparam longint K_BU = ((longint'(20172) <<< FRAC) + 5000) / 10000;
  localparam logic [PADDR_W-1:0] ADDR_LINE_PAIRS = {REG_LINE_PAIRS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4);
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  typedef struct packed {
    bgr_t first;
    bgr_t second;
    logic eol;
  } pixel_pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         luma_even = '0;
  logic [7:0]         chroma_blue = '0;
  logic [7:0]         luma_odd = '0;
  logic [7:0]         chroma_red = '0;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         first_blue;
  logic [7:0]         first_green;
  logic [7:0]         first_red;
  logic [7:0]         second_blue;
  logic [7:0]         second_green;
  logic [7:0]         second_red;
  logic               end_of_line;

  logic [LINE_PAIRS_W-1:0] line_pairs_shadow = LINE_PAIRS_RESET;
  int unsigned             row_col = 0;
  logic                    row_is_odd = 1'b0;
  logic [15:0]             chroma_store [MAX_PAIRS];
  logic                    chroma_valid [MAX_PAIRS];

  pixel_pair_t pending_pixels [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  yuy2_to_bgra_converter u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .luma_even    (luma_even),
    .chroma_blue  (chroma_blue),
    .luma_odd     (luma_odd),
    .chroma_red   (chroma_red),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_blue   (first_blue),
    .first_green  (first_green),
    .first_red    (first_red),
    .second_blue  (second_blue),
    .second_green (second_green),
    .second_red   (second_red),
    .end_of_line  (end_of_line)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("yuy2_to_bgra_converter_tb: errors");
    $finish;
  end

  function automatic logic [7:0] clamp_channel(longint acc);
    longint q;
    if (acc <= 0) return 8'd0;
    q = acc >>> FRAC;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic bgr_t to_bgr(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
    longint ty;
    longint u;
    longint v;
    bgr_t   px;
    ty = K_Y * (longint'(luma) - 16);
    u = longint'(cb) - 128;
    v = longint'(cr) - 128;
    px.blue = clamp_channel(ty + K_BU * u);
    px.green = clamp_channel(ty - K_GU * u - K_GV * v);
    px.red = clamp_channel(ty + K_RV * v);
    return px;
  endfunction

  function automatic int unsigned store_index(int unsigned col);
    return (col >= MAX_PAIRS) ? MAX_PAIRS - 1 : col;
  endfunction

  function automatic pixel_pair_t convert_macropixel(logic [7:0] y0, logic [7:0] cb,
                                                     logic [7:0] y1, logic [7:0] cr,
                                                     logic fs);
    int unsigned eff;
    int unsigned col;
    logic [7:0]  use_cb;
    logic [7:0]  use_cr;
    pixel_pair_t res;
    eff = line_pairs_shadow;
    if (eff == 0) eff = 1;
    if (eff > MAX_PAIRS) eff = MAX_PAIRS;
    if (fs) begin
      row_col = 0;
      row_is_odd = 1'b0;
    end
    col = store_index(row_col);
    if (!row_is_odd) begin
      chroma_store[col] = {cr, cb};
      chroma_valid[col] = 1'b1;
      use_cb = cb;
      use_cr = cr;
    end else begin
      {use_cr, use_cb} = chroma_store[col];
    end
    res.first = to_bgr(y0, use_cb, use_cr);
    res.second = to_bgr(y1, use_cb, use_cr);
    res.eol = (row_col + 1 >= eff);
    if (res.eol) begin
      row_col = 0;
      row_is_odd = ~row_is_odd;
    end else begin
      row_col = row_col + 1;
    end
    return res;
  endfunction

  function automatic logic [7:0] random_sample();
    case ($urandom_range(15))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: output request expected none actual eol=%0b", $time, end_of_line);
      end else begin
        want = pending_pixels.pop_front();
        check_field("first_blue", want.first.blue, first_blue);
        check_field("first_green", want.first.green, first_green);
        check_field("first_red", want.first.red, first_red);
        check_field("second_blue", want.second.blue, second_blue);
        check_field("second_green", want.second.green, second_green);
        check_field("second_red", want.second.red, second_red);
        check_field("end_of_line", 8'(want.eol), 8'(end_of_line));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_macropixel(input logic [7:0] y0, input logic [7:0] cb,
                                 input logic [7:0] y1, input logic [7:0] cr, input logic fs);
    logic start;
    start = fs;
    // restart the frame rather than read a chroma entry never written
    if (!start && row_is_odd && !chroma_valid[store_index(row_col)]) start = 1'b1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    luma_even <= y0;
    chroma_blue <= cb;
    luma_odd <= y1;
    chroma_red <= cr;
    frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(convert_macropixel(y0, cb, y1, cr, start));
  endtask

  task automatic send_random();
    send_macropixel(random_sample(), random_sample(), random_sample(), random_sample(),
                    $urandom_range(49) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_LINE_PAIRS) line_pairs_shadow = data[LINE_PAIRS_W-1:0];
  endtask

  task automatic apb_read_line_pairs();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_LINE_PAIRS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(line_pairs_shadow)) begin
      mismatch_count++;
      $display("%0t: line_pairs read expected %0d actual %0d", $time, line_pairs_shadow,
               prdata);
    end
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_line_pairs(input logic [PDATA_W-1:0] value);
    drain();
    apb_write(ADDR_LINE_PAIRS, value);
    apb_read_line_pairs();
    apb_release();
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  task automatic test_register_access();
    apb_read_line_pairs();
    apb_write(ADDR_SPARE, 32'h0000_0123);
    apb_read_line_pairs();
    apb_write(ADDR_LINE_PAIRS, 32'hFFFF_F803);
    apb_read_line_pairs();
    apb_write(ADDR_LINE_PAIRS, 32'h0000_07FF);
    apb_read_line_pairs();
    apb_release();
  endtask

  task automatic test_color_extremes();
    set_line_pairs(4);
    send_macropixel(8'd0, 8'd0, 8'd255, 8'd0, 1'b1);
    send_macropixel(8'd16, 8'd255, 8'd235, 8'd255, 1'b0);
    send_macropixel(8'd255, 8'd128, 8'd0, 8'd128, 1'b0);
    send_macropixel(8'd128, 8'd0, 8'd128, 8'd255, 1'b0);
    send_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    send_macropixel(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
    send_macropixel(8'd235, 8'd37, 8'd200, 8'd219, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_macropixel(8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
  endtask

  task automatic test_line_length_limits();
    set_line_pairs(0);
    repeat (3) send_random();
    set_line_pairs(8);
    send_macropixel(8'd90, 8'd10, 8'd91, 8'd240, 1'b1);
    repeat (4) send_random();
    // shorten the line while the row is half done
    set_line_pairs(2);
    repeat (3) send_macropixel(random_sample(), random_sample(), random_sample(),
                               random_sample(), 1'b0);
  endtask

  task automatic test_full_line();
    set_line_pairs(32'h0000_07FF);
    send_macropixel(random_sample(), random_sample(), random_sample(), random_sample(), 1'b1);
    repeat (MAX_PAIRS) send_macropixel(random_sample(), random_sample(),
                                       random_sample(), random_sample(), 1'b0);
  endtask

  task automatic test_random_traffic();
    int send_pcts [4] = '{0, 63, 0, 7};
    int recv_pcts [4] = '{0, 0, 63, 7};
    for (int m = 0; m < 4; m++) begin
      set_idling(send_pcts[m], recv_pcts[m]);
      for (int b = 0; b < 3; b++) begin
        set_line_pairs(($urandom_range(9) == 0) ? 1 : $urandom_range(2, 20));
        repeat (15) send_random();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_PAIRS; i++) chroma_valid[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_color_extremes();
    test_line_length_limits();
    test_full_line();
    test_random_traffic();
    drain();
    if (mismatch_count == 0) begin
      $display("yuy2_to_bgra_converter_tb: clean");
    end else begin
      $display("yuy2_to_bgra_converter_tb: errors");
    end
    $finish;
  end

endmodule
